### src/rce_pkg.sv
// Shared constants, types and helper functions of the rotor cipher engine.
// Used by the controller, the datapath and the checker.
package rce_pkg;

   localparam int ROTOR_COUNT = 4;
   localparam int NSYM = 94;
   localparam int SYM_W = 7;
   localparam int ROT_W = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;
   localparam int MEM_DEPTH = ROTOR_COUNT * NSYM;
   localparam int MEM_AW = $clog2(MEM_DEPTH);

   localparam int SEED_W = 15;
   localparam int SEED_START = 123;
   localparam int LCG_MULT = 5;
   localparam int KEY_LEN = 13;
   localparam int KEY_IDX_W = 4;
   localparam int KEY_LOW_W = 64;
   localparam int KEY_HIGH_W = 40;

   // The seed stays below 2^15, so reducing it by 65521 and masking it leaves it unchanged.
   // Its residue by 94 comes from a reciprocal product with one correction step.
   localparam int RECIP_MUL = 22310;
   localparam int RECIP_W = 15;
   localparam int RECIP_SHIFT = 21;
   localparam int PROD_W = SEED_W + RECIP_W;
   localparam int Q_W = PROD_W - RECIP_SHIFT;

   localparam logic [7:0] CHAR_LO = 8'h20;
   localparam logic [7:0] CHAR_HI = 8'h7d;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b1;

   localparam logic [1:0] CMD_SETUP = 2'd0;
   localparam logic [1:0] CMD_ENCIPHER = 2'd1;
   localparam logic [1:0] CMD_PASS = 2'd2;

   typedef enum logic [1:0] {
      RSP_PASS,
      RSP_ENC,
      RSP_SETUP
   } rsp_kind_type;

   typedef enum logic [5:0] {
      OP_NONE,
      OP_START_SETUP,
      OP_SEED_STEP,
      OP_IDENT_ORD,
      OP_DRAW_SEED,
      OP_DRAW_MUL,
      OP_DRAW_MOD,
      OP_ORD_RD_I,
      OP_ORD_RD_K,
      OP_ORD_WR_I,
      OP_ORD_WR_K,
      OP_PAIR_RD_A,
      OP_PAIR_RD_B,
      OP_REFL_RD_A,
      OP_REFL_RD_B,
      OP_REFL_WR_A,
      OP_REFL_WR_B,
      OP_FWD_IDENT,
      OP_FWD_RD_I,
      OP_FWD_RD_K,
      OP_FWD_WR_I,
      OP_FWD_WR_K,
      OP_INV_RD,
      OP_INV_WR,
      OP_NEXT_ROTOR,
      OP_LATCH,
      OP_ENC_START,
      OP_ENC_FWD_RD,
      OP_ENC_FWD_TAKE,
      OP_ENC_REFL_RD,
      OP_ENC_REFL_TAKE,
      OP_ENC_INV_RD,
      OP_ENC_INV_TAKE,
      OP_ENC_STEP,
      OP_LOAD_RSP
   } op_type;

   typedef struct packed {
      op_type       op;
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic idx_pair_last;
      logic key_last;
      logic rot_last;
      logic rot_first;
      logic char_in_range;
   } dp_status_type;

   function automatic logic [SYM_W-1:0] add_mod(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
      logic [SYM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (SYM_W+1)'(NSYM)) begin
         return SYM_W'(s - (SYM_W+1)'(NSYM));
      end
      return s[SYM_W-1:0];
   endfunction

   function automatic logic [SYM_W-1:0] sub_mod(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
      logic [SYM_W:0] t;
      t = {1'b0, a} + (SYM_W+1)'(NSYM) - {1'b0, b};
      if (a >= b) begin
         return a - b;
      end
      return t[SYM_W-1:0];
   endfunction

endpackage

### src/rce_ifs.sv
// Valid/ready channel interfaces for request and response beats.
interface rce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] char_in;

   modport source (output valid, output command, output char_in, input ready);
   modport sink (input valid, input command, input char_in, output ready);
endinterface

interface rce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       was_enciphered;
   logic       setup_done;

   modport source (output valid, output char_out, output was_enciphered, output setup_done,
                   input ready);
   modport sink (input valid, input char_out, input was_enciphered, input setup_done,
                 output ready);
endinterface

### src/rce_ctrl.sv
// Sequencer of the rotor cipher engine: one-hot state machine that issues datapath operations.
// Depends on rce_pkg for the command and status structs.
module rce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rce_pkg::dp_status_type status,
   output rce_pkg::dp_cmd_type   cmd
);
   import rce_pkg::*;

   typedef enum logic [34:0] {
      ST_IDLE     = 35'b1 << 0,
      ST_SEED     = 35'b1 << 1,
      ST_IDENT    = 35'b1 << 2,
      ST_SDRAW1   = 35'b1 << 3,
      ST_SDRAW2   = 35'b1 << 4,
      ST_SDRAW3   = 35'b1 << 5,
      ST_SRD_I    = 35'b1 << 6,
      ST_SRD_K    = 35'b1 << 7,
      ST_SWR_I    = 35'b1 << 8,
      ST_SWR_K    = 35'b1 << 9,
      ST_P_RDA    = 35'b1 << 10,
      ST_P_RDB    = 35'b1 << 11,
      ST_P_RRA    = 35'b1 << 12,
      ST_P_RRB    = 35'b1 << 13,
      ST_P_WRA    = 35'b1 << 14,
      ST_P_WRB    = 35'b1 << 15,
      ST_F_IDENT  = 35'b1 << 16,
      ST_FDRAW1   = 35'b1 << 17,
      ST_FDRAW2   = 35'b1 << 18,
      ST_FDRAW3   = 35'b1 << 19,
      ST_F_RD_I   = 35'b1 << 20,
      ST_F_RD_K   = 35'b1 << 21,
      ST_F_WR_I   = 35'b1 << 22,
      ST_F_WR_K   = 35'b1 << 23,
      ST_INV_RD   = 35'b1 << 24,
      ST_INV_WR   = 35'b1 << 25,
      ST_NEXT_ROT = 35'b1 << 26,
      ST_E_FRD    = 35'b1 << 27,
      ST_E_FTAKE  = 35'b1 << 28,
      ST_E_RRD    = 35'b1 << 29,
      ST_E_RTAKE  = 35'b1 << 30,
      ST_E_IRD    = 35'b1 << 31,
      ST_E_ITAKE  = 35'b1 << 32,
      ST_E_STEP   = 35'b1 << 33,
      ST_RESULT   = 35'b1 << 34
   } state_type;

   state_type    state_ff, state_in;
   rsp_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff <= RSP_PASS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      cmd.op = OP_NONE;
      cmd.kind = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_command == CMD_SETUP) begin
                  cmd.op = OP_START_SETUP;
                  kind_in = RSP_SETUP;
                  state_in = ST_SEED;
               end else if (req_command == CMD_ENCIPHER && status.char_in_range) begin
                  cmd.op = OP_ENC_START;
                  kind_in = RSP_ENC;
                  state_in = ST_E_FRD;
               end else begin
                  cmd.op = OP_LATCH;
                  kind_in = RSP_PASS;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SEED: begin
            cmd.op = OP_SEED_STEP;
            if (status.key_last) begin
               state_in = ST_IDENT;
            end
         end
         ST_IDENT: begin
            cmd.op = OP_IDENT_ORD;
            if (status.idx_last) begin
               state_in = ST_SDRAW1;
            end
         end
         ST_SDRAW1: begin
            cmd.op = OP_DRAW_SEED;
            state_in = ST_SDRAW2;
         end
         ST_SDRAW2: begin
            cmd.op = OP_DRAW_MUL;
            state_in = ST_SDRAW3;
         end
         ST_SDRAW3: begin
            cmd.op = OP_DRAW_MOD;
            state_in = ST_SRD_I;
         end
         ST_SRD_I: begin
            cmd.op = OP_ORD_RD_I;
            state_in = ST_SRD_K;
         end
         ST_SRD_K: begin
            cmd.op = OP_ORD_RD_K;
            state_in = ST_SWR_I;
         end
         ST_SWR_I: begin
            cmd.op = OP_ORD_WR_I;
            state_in = ST_SWR_K;
         end
         ST_SWR_K: begin
            cmd.op = OP_ORD_WR_K;
            state_in = status.idx_last ? ST_P_RDA : ST_SDRAW1;
         end
         ST_P_RDA: begin
            cmd.op = OP_PAIR_RD_A;
            state_in = ST_P_RDB;
         end
         ST_P_RDB: begin
            cmd.op = OP_PAIR_RD_B;
            state_in = ST_P_RRA;
         end
         ST_P_RRA: begin
            cmd.op = OP_REFL_RD_A;
            state_in = ST_P_RRB;
         end
         ST_P_RRB: begin
            cmd.op = OP_REFL_RD_B;
            state_in = ST_P_WRA;
         end
         ST_P_WRA: begin
            cmd.op = OP_REFL_WR_A;
            state_in = ST_P_WRB;
         end
         ST_P_WRB: begin
            cmd.op = OP_REFL_WR_B;
            state_in = status.idx_pair_last ? ST_F_IDENT : ST_P_RDA;
         end
         ST_F_IDENT: begin
            cmd.op = OP_FWD_IDENT;
            if (status.idx_last) begin
               state_in = ST_FDRAW1;
            end
         end
         ST_FDRAW1: begin
            cmd.op = OP_DRAW_SEED;
            state_in = ST_FDRAW2;
         end
         ST_FDRAW2: begin
            cmd.op = OP_DRAW_MUL;
            state_in = ST_FDRAW3;
         end
         ST_FDRAW3: begin
            cmd.op = OP_DRAW_MOD;
            state_in = ST_F_RD_I;
         end
         ST_F_RD_I: begin
            cmd.op = OP_FWD_RD_I;
            state_in = ST_F_RD_K;
         end
         ST_F_RD_K: begin
            cmd.op = OP_FWD_RD_K;
            state_in = ST_F_WR_I;
         end
         ST_F_WR_I: begin
            cmd.op = OP_FWD_WR_I;
            state_in = ST_F_WR_K;
         end
         ST_F_WR_K: begin
            cmd.op = OP_FWD_WR_K;
            state_in = status.idx_last ? ST_INV_RD : ST_FDRAW1;
         end
         ST_INV_RD: begin
            cmd.op = OP_INV_RD;
            state_in = ST_INV_WR;
         end
         ST_INV_WR: begin
            cmd.op = OP_INV_WR;
            priority if (!status.idx_last) begin
               state_in = ST_INV_RD;
            end else if (status.rot_last) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_NEXT_ROT;
            end
         end
         ST_NEXT_ROT: begin
            cmd.op = OP_NEXT_ROTOR;
            state_in = ST_F_IDENT;
         end
         ST_E_FRD: begin
            cmd.op = OP_ENC_FWD_RD;
            state_in = ST_E_FTAKE;
         end
         ST_E_FTAKE: begin
            cmd.op = OP_ENC_FWD_TAKE;
            state_in = status.rot_last ? ST_E_RRD : ST_E_FRD;
         end
         ST_E_RRD: begin
            cmd.op = OP_ENC_REFL_RD;
            state_in = ST_E_RTAKE;
         end
         ST_E_RTAKE: begin
            cmd.op = OP_ENC_REFL_TAKE;
            state_in = ST_E_IRD;
         end
         ST_E_IRD: begin
            cmd.op = OP_ENC_INV_RD;
            state_in = ST_E_ITAKE;
         end
         ST_E_ITAKE: begin
            cmd.op = OP_ENC_INV_TAKE;
            state_in = status.rot_first ? ST_E_STEP : ST_E_IRD;
         end
         ST_E_STEP: begin
            cmd.op = OP_ENC_STEP;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = OP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/rce_datapath.sv
// Datapath of the rotor cipher engine: key registers, LCG, rotor and reflector memories,
// offsets and the response register. Depends on rce_pkg.
module rce_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rce_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rce_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [7:0]                           req_char,
   input  rce_pkg::dp_cmd_type                  cmd,
   output rce_pkg::dp_status_type               status,
   output logic [7:0]                           rsp_char_out,
   output logic                                 rsp_was_enciphered,
   output logic                                 rsp_setup_done
);
   import rce_pkg::*;

   logic [KEY_LOW_W-1:0]  key_low_ff;
   logic [KEY_HIGH_W-1:0] key_high_ff;
   logic [SEED_W-1:0]     seed_ff, seed_in;
   logic [SYM_W-1:0]      idx_ff, idx_in;
   logic [KEY_IDX_W-1:0]  kidx_ff, kidx_in;
   logic [ROT_W-1:0]      rot_ff, rot_in;
   logic [MEM_AW-1:0]     base_ff, base_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [SYM_W-1:0]      k_ff, k_in;
   logic [SYM_W-1:0]      t_ff, t_in;
   logic [SYM_W-1:0]      a_ff, a_in;
   logic [SYM_W-1:0]      b_ff, b_in;
   logic [SYM_W-1:0]      v_ff, v_in;
   logic [7:0]            char_ff, char_in;
   logic [SYM_W-1:0]      off_ff [ROTOR_COUNT];
   logic [SYM_W-1:0]      off_in [ROTOR_COUNT];
   logic [SYM_W-1:0]      off_step [ROTOR_COUNT];
   logic [SYM_W-1:0]      refl_off_ff, refl_off_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_enc_ff, rsp_enc_in;
   logic                  rsp_setup_ff, rsp_setup_in;

   logic [SYM_W-1:0] fwd_mem [MEM_DEPTH];
   logic [SYM_W-1:0] inv_mem [MEM_DEPTH];
   logic [SYM_W-1:0] refl_mem [NSYM];
   logic [SYM_W-1:0] ord_mem [NSYM];
   logic [SYM_W-1:0] fwd_rd_ff, inv_rd_ff, refl_rd_ff, ord_rd_ff;

   logic              fwd_we, inv_we, refl_we, ord_we;
   logic [MEM_AW-1:0] fwd_waddr, fwd_raddr, inv_waddr, inv_raddr;
   logic [SYM_W-1:0]  refl_waddr, refl_raddr, ord_waddr, ord_raddr;
   logic [SYM_W-1:0]  fwd_wdata, inv_wdata, refl_wdata, ord_wdata;

   logic [8*KEY_LEN-1:0]  key_all;
   logic [7:0]            key_byte;
   logic [SEED_W+7:0]     seed_mul;
   logic [SEED_W+2:0]     lcg_sum;
   logic [PROD_W-1:0]     recip_prod;
   logic [SEED_W:0]       rem_full;
   logic [SYM_W-1:0]      idx_next;
   logic [KEY_IDX_W-1:0]  kidx_next;
   logic [SYM_W-1:0]      off_cur;
   logic                  step_carry;

   assign key_all = {key_high_ff, key_low_ff};
   assign key_byte = key_all[{kidx_ff, 3'b000} +: 8];
   assign seed_mul = seed_ff * key_byte;
   assign lcg_sum = {3'b000, seed_ff} * (SEED_W+3)'(LCG_MULT) + (SEED_W+3)'(key_byte);
   assign recip_prod = seed_ff * RECIP_W'(RECIP_MUL);
   assign rem_full = {1'b0, seed_ff} - (SEED_W+1)'(q_ff * NSYM);
   assign off_cur = off_ff[rot_ff];

   assign status.idx_last = (idx_ff == SYM_W'(NSYM - 1));
   assign status.idx_pair_last = (idx_ff == SYM_W'(NSYM - 2));
   assign status.key_last = (kidx_ff == KEY_IDX_W'(KEY_LEN - 1));
   assign status.rot_last = (rot_ff == ROT_W'(ROTOR_COUNT - 1));
   assign status.rot_first = (rot_ff == '0);
   assign status.char_in_range = (req_char >= CHAR_LO) && (req_char <= CHAR_HI);

   assign idx_next = status.idx_last ? '0 : idx_ff + 1'b1;
   assign kidx_next = status.key_last ? '0 : kidx_ff + 1'b1;

   always_comb begin
      step_carry = 1'b1;
      for (int r = 0; r < ROTOR_COUNT; r++) begin
         off_step[r] = off_ff[r];
         if (step_carry) begin
            if (off_ff[r] == SYM_W'(NSYM - 1)) begin
               off_step[r] = '0;
            end else begin
               off_step[r] = off_ff[r] + 1'b1;
               step_carry = 1'b0;
            end
         end
      end
   end

   always_comb begin
      seed_in = seed_ff;
      idx_in = idx_ff;
      kidx_in = kidx_ff;
      rot_in = rot_ff;
      base_in = base_ff;
      q_in = q_ff;
      k_in = k_ff;
      t_in = t_ff;
      a_in = a_ff;
      b_in = b_ff;
      v_in = v_ff;
      char_in = char_ff;
      off_in = off_ff;
      refl_off_in = refl_off_ff;
      rsp_char_in = rsp_char_ff;
      rsp_enc_in = rsp_enc_ff;
      rsp_setup_in = rsp_setup_ff;
      fwd_we = 1'b0;
      inv_we = 1'b0;
      refl_we = 1'b0;
      ord_we = 1'b0;
      fwd_waddr = base_ff + MEM_AW'(idx_ff);
      fwd_raddr = base_ff + MEM_AW'(idx_ff);
      fwd_wdata = fwd_rd_ff;
      inv_waddr = base_ff + MEM_AW'(fwd_rd_ff);
      inv_raddr = base_ff + MEM_AW'(v_ff);
      inv_wdata = idx_ff;
      refl_waddr = idx_ff;
      refl_raddr = a_ff;
      refl_wdata = idx_ff;
      ord_waddr = idx_ff;
      ord_raddr = idx_ff;
      ord_wdata = idx_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_START_SETUP: begin
            seed_in = SEED_W'(SEED_START);
            kidx_in = '0;
            idx_in = '0;
            rot_in = '0;
            base_in = '0;
            for (int r = 0; r < ROTOR_COUNT; r++) begin
               off_in[r] = '0;
            end
            refl_off_in = '0;
         end
         OP_SEED_STEP: begin
            seed_in = seed_mul[SEED_W-1:0] + SEED_W'(kidx_ff);
            kidx_in = kidx_next;
         end
         OP_IDENT_ORD: begin
            ord_we = 1'b1;
            refl_we = 1'b1;
            idx_in = idx_next;
         end
         OP_DRAW_SEED: begin
            seed_in = lcg_sum[SEED_W-1:0];
         end
         OP_DRAW_MUL: begin
            q_in = recip_prod[RECIP_SHIFT +: Q_W];
         end
         OP_DRAW_MOD: begin
            k_in = (rem_full >= (SEED_W+1)'(NSYM)) ? SYM_W'(rem_full - (SEED_W+1)'(NSYM))
                                                   : rem_full[SYM_W-1:0];
         end
         OP_ORD_RD_I: begin
            ord_raddr = idx_ff;
         end
         OP_ORD_RD_K: begin
            t_in = ord_rd_ff;
            ord_raddr = k_ff;
         end
         OP_ORD_WR_I: begin
            ord_we = 1'b1;
            ord_wdata = ord_rd_ff;
         end
         OP_ORD_WR_K: begin
            ord_we = 1'b1;
            ord_waddr = k_ff;
            ord_wdata = t_ff;
            idx_in = idx_next;
            kidx_in = kidx_next;
         end
         OP_PAIR_RD_A: begin
            ord_raddr = idx_ff;
         end
         OP_PAIR_RD_B: begin
            a_in = ord_rd_ff;
            ord_raddr = idx_ff + 1'b1;
         end
         OP_REFL_RD_A: begin
            b_in = ord_rd_ff;
            refl_raddr = a_ff;
         end
         OP_REFL_RD_B: begin
            t_in = refl_rd_ff;
            refl_raddr = b_ff;
         end
         OP_REFL_WR_A: begin
            refl_we = 1'b1;
            refl_waddr = a_ff;
            refl_wdata = refl_rd_ff;
         end
         OP_REFL_WR_B: begin
            refl_we = 1'b1;
            refl_waddr = b_ff;
            refl_wdata = t_ff;
            idx_in = status.idx_pair_last ? '0 : idx_ff + SYM_W'(2);
         end
         OP_FWD_IDENT: begin
            fwd_we = 1'b1;
            fwd_wdata = idx_ff;
            idx_in = idx_next;
            kidx_in = '0;
         end
         OP_FWD_RD_I: begin
            fwd_raddr = base_ff + MEM_AW'(idx_ff);
         end
         OP_FWD_RD_K: begin
            t_in = fwd_rd_ff;
            fwd_raddr = base_ff + MEM_AW'(k_ff);
         end
         OP_FWD_WR_I: begin
            fwd_we = 1'b1;
            fwd_wdata = fwd_rd_ff;
         end
         OP_FWD_WR_K: begin
            fwd_we = 1'b1;
            fwd_waddr = base_ff + MEM_AW'(k_ff);
            fwd_wdata = t_ff;
            idx_in = idx_next;
            kidx_in = kidx_next;
         end
         OP_INV_RD: begin
            fwd_raddr = base_ff + MEM_AW'(idx_ff);
         end
         OP_INV_WR: begin
            inv_we = 1'b1;
            idx_in = idx_next;
         end
         OP_NEXT_ROTOR: begin
            rot_in = rot_ff + 1'b1;
            base_in = base_ff + MEM_AW'(NSYM);
            idx_in = '0;
            kidx_in = '0;
         end
         OP_LATCH: begin
            char_in = req_char;
         end
         OP_ENC_START: begin
            char_in = req_char;
            v_in = SYM_W'(req_char - CHAR_LO);
            rot_in = '0;
            base_in = '0;
         end
         OP_ENC_FWD_RD: begin
            fwd_raddr = base_ff + MEM_AW'(add_mod(v_ff, off_cur));
         end
         OP_ENC_FWD_TAKE: begin
            v_in = fwd_rd_ff;
            if (!status.rot_last) begin
               rot_in = rot_ff + 1'b1;
               base_in = base_ff + MEM_AW'(NSYM);
            end
         end
         OP_ENC_REFL_RD: begin
            refl_raddr = add_mod(v_ff, refl_off_ff);
         end
         OP_ENC_REFL_TAKE: begin
            v_in = sub_mod(refl_rd_ff, refl_off_ff);
         end
         OP_ENC_INV_RD: begin
            inv_raddr = base_ff + MEM_AW'(v_ff);
         end
         OP_ENC_INV_TAKE: begin
            v_in = sub_mod(inv_rd_ff, off_cur);
            if (!status.rot_first) begin
               rot_in = rot_ff - 1'b1;
               base_in = base_ff - MEM_AW'(NSYM);
            end
         end
         OP_ENC_STEP: begin
            off_in = off_step;
            refl_off_in = (refl_off_ff == SYM_W'(NSYM - 1)) ? '0 : refl_off_ff + 1'b1;
         end
         OP_LOAD_RSP: begin
            unique case (cmd.kind)
               RSP_SETUP: begin
                  rsp_char_in = '0;
                  rsp_enc_in = 1'b0;
                  rsp_setup_in = 1'b1;
               end
               RSP_ENC: begin
                  rsp_char_in = {1'b0, v_ff} + CHAR_LO;
                  rsp_enc_in = 1'b1;
                  rsp_setup_in = 1'b0;
               end
               default: begin
                  rsp_char_in = char_ff;
                  rsp_enc_in = 1'b0;
                  rsp_setup_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
         seed_ff <= '0;
         idx_ff <= '0;
         kidx_ff <= '0;
         rot_ff <= '0;
         base_ff <= '0;
         for (int r = 0; r < ROTOR_COUNT; r++) begin
            off_ff[r] <= '0;
         end
         refl_off_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_KEY_LOW) begin
            key_low_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata[KEY_HIGH_W-1:0];
         end
         seed_ff <= seed_in;
         idx_ff <= idx_in;
         kidx_ff <= kidx_in;
         rot_ff <= rot_in;
         base_ff <= base_in;
         off_ff <= off_in;
         refl_off_ff <= refl_off_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      k_ff <= k_in;
      t_ff <= t_in;
      a_ff <= a_in;
      b_ff <= b_in;
      v_ff <= v_in;
      char_ff <= char_in;
      rsp_char_ff <= rsp_char_in;
      rsp_enc_ff <= rsp_enc_in;
      rsp_setup_ff <= rsp_setup_in;
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[fwd_waddr] <= fwd_wdata;
      end
      fwd_rd_ff <= fwd_mem[fwd_raddr];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[inv_waddr] <= inv_wdata;
      end
      inv_rd_ff <= inv_mem[inv_raddr];
   end

   always_ff @(posedge clock) begin
      if (refl_we) begin
         refl_mem[refl_waddr] <= refl_wdata;
      end
      refl_rd_ff <= refl_mem[refl_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= ord_mem[ord_raddr];
   end

   assign rsp_char_out = rsp_char_ff;
   assign rsp_was_enciphered = rsp_enc_ff;
   assign rsp_setup_done = rsp_setup_ff;

endmodule

### src/rotor_cipher_engine.sv
// Encipher: an accepted beat's response follows the chain of registered rotor, reflector
// and inverse memory reads. Pass and out-of-range bytes go from idle straight to the
// result state. The key schedule length is set by the swap sequences on the table memories.
// One beat is in work at a time; a new beat is accepted while the previous response waits.
// Synchronous active-high reset clears control state, key registers and rotor positions.
module rotor_cipher_engine (
   input  logic                            clock,
   input  logic                            reset,
   rce_req_if.sink                         req_bus,
   rce_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [rce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rce_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rce_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   rce_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   rce_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_char           (req_bus.char_in),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .rsp_char_out       (rsp_bus.char_out),
      .rsp_was_enciphered (rsp_bus.was_enciphered),
      .rsp_setup_done     (rsp_bus.setup_done)
   );

endmodule

### src/rce_checker.sv
// Port-level checker for the rotor cipher engine and its bind to the top level.
// Depends on rce_pkg for the printable character range.
module rce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_out,
   input logic       rsp_was_enciphered,
   input logic       rsp_setup_done
);
   import rce_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped before it was taken");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_beat |-> pending_ff < 2'd2)
      else $error("more than two beats in flight");

   a_enc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_enciphered |-> rsp_char_out >= CHAR_LO && rsp_char_out <= CHAR_HI)
      else $error("enciphered byte outside the symbol range");

   a_setup_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_setup_done |-> rsp_char_out == 8'h00 && !rsp_was_enciphered)
      else $error("malformed key schedule response");

endmodule

bind rotor_cipher_engine rce_checker u_rce_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_char_out       (rsp_bus.char_out),
   .rsp_was_enciphered (rsp_bus.was_enciphered),
   .rsp_setup_done     (rsp_bus.setup_done)
);
